// File: src/sqge_pkg.sv
// ----------------------------------------------------------------------------
// Statevector gate engine package
// Shared widths, codes and the fixed-point rounding helper.
// ----------------------------------------------------------------------------
package sqge_pkg;

    localparam int QUBITS    = 10;
    localparam int AMP_BITS  = 16;
    localparam int FRAC_BITS = AMP_BITS - 1;
    localparam int DEPTH     = 1 << QUBITS;
    localparam int ADDR_W    = QUBITS;
    localparam int QCNT_W    = 4;
    localparam int PROD_W    = 2 * AMP_BITS;
    localparam int ACC_W     = PROD_W + 3;

    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_GATE = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic signed [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
    localparam logic signed [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

    function automatic logic signed [AMP_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] r;
        begin
            r = (acc + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (r > ACC_W'(AMP_MAX))
                round_sat = AMP_MAX;
            else if (r < ACC_W'(AMP_MIN))
                round_sat = AMP_MIN;
            else
                round_sat = r[AMP_BITS-1:0];
        end
    endfunction

endpackage

// File: src/sqge_mac.sv
// ----------------------------------------------------------------------------
// Statevector gate engine multiply-accumulate unit
// One signed 16x16 multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module sqge_mac
    import sqge_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr,
    input  logic                       en,
    input  logic                       neg,
    input  logic signed [AMP_BITS-1:0] a,
    input  logic signed [AMP_BITS-1:0] b,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic                     en_reg;
    logic                     clr_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;

    assign term = neg_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
    assign base = clr_reg ? '0 : acc_reg;
    assign acc  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            clr_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            en_reg  <= en;
            clr_reg <= clr;
            if (en_reg)
                acc_reg <= base + term;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        neg_reg  <= neg;
    end

endmodule

// File: src/statevector_qubit_gate_engine.sv
// ----------------------------------------------------------------------------
// Statevector single-qubit gate engine
// Holds 2^n Q1.15 complex amplitudes and applies init, gate and read requests.
// ----------------------------------------------------------------------------
// A request enters on s_axis (tdata holds action, target, index and matrix),
// and exactly one result leaves on m_axis. The block takes one request at a
// time: s_axis_tready is low from acceptance until the result is taken.
// An init request sweeps the whole store, one entry a cycle.
// A gate request runs each amplitude pair through the one shared multiplier:
// two reads, sixteen products and two writes for each pair. active_qubits is
// written through cfg_we and cfg_data; the user must write it only while idle,
// since the block does not enforce this. Reset sets it to ten. The amplitude
// store is not cleared by reset; send an init first.
// When the receiver stalls, the result waits in the output register.
// ----------------------------------------------------------------------------
module statevector_qubit_gate_engine
    import sqge_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0], target_qubit[5:2], amp_index[15:6], m00_re, m00_im, m01_re,
    // m01_im, m10_re, m10_im, m11_re, m11_im (16 bits each from bit 16 up)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_re[15:0], out_im[31:16], probability[47:32], status[48]
    output logic [55:0]  m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RDA, S_RDB, S_MUL, S_WAIT, S_WRA, S_WRB,
        S_RDQ, S_RDQ2, S_SQ, S_SQW, S_OUT
    } state_t;

    state_t                      state_reg;
    logic [QCNT_W-1:0]           aq_reg;
    logic [QCNT_W-1:0]           nq;
    logic [1:0]                  act;
    logic [QCNT_W-1:0]           tq;
    logic [ADDR_W-1:0]           idx;
    logic signed [AMP_BITS-1:0]  m_reg [8];
    logic [QCNT_W-1:0]           t_reg;
    logic [ADDR_W:0]             cnt_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic [4:0]                  step_reg;
    logic [ADDR_W:0]             count;
    logic [ADDR_W-1:0]           bit_mask;
    logic [ADDR_W-1:0]           lo_addr;

    logic signed [AMP_BITS-1:0]  mem_re [DEPTH];
    logic signed [AMP_BITS-1:0]  mem_im [DEPTH];
    logic signed [AMP_BITS-1:0]  rd_re_reg, rd_im_reg;
    logic signed [AMP_BITS-1:0]  ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [AMP_BITS-1:0]  nr_reg [4];
    logic                        we;
    logic [ADDR_W-1:0]           wa;
    logic signed [AMP_BITS-1:0]  wd_re, wd_im;
    logic [ADDR_W-1:0]           ra;

    logic                        mac_clr, mac_en, mac_neg;
    logic signed [AMP_BITS-1:0]  mac_a, mac_b;
    logic signed [ACC_W-1:0]     mac_acc;

    logic [15:0]                 ore_reg, oim_reg, prob_reg;
    logic                        st_reg;
    logic [ACC_W-1:0]            sq_round;

    assign act = s_axis_tdata[1:0];
    assign tq  = s_axis_tdata[5:2];
    assign idx = s_axis_tdata[15:6];
    assign nq  = (aq_reg == '0) ? QCNT_W'(1) :
                 (aq_reg > QCNT_W'(QUBITS)) ? QCNT_W'(QUBITS) : aq_reg;
    assign count    = (ADDR_W+1)'(1) << nq;
    assign bit_mask = ADDR_W'(1) << t_reg;
    assign lo_addr  = addr_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {7'd0, st_reg, prob_reg, oim_reg, ore_reg};

    // Product schedule: steps 0..15, four terms per output component.
    // Component k = step[3:2]: 0 lo_re, 1 lo_im, 2 hi_re, 3 hi_im.
    always_comb
    begin
        logic [1:0] k;
        logic [1:0] j;
        logic       row;
        k = step_reg[3:2];
        j = step_reg[1:0];
        row = k[1];
        mac_clr = (j == 2'd0);
        mac_en  = (state_reg == S_MUL) || (state_reg == S_SQ);
        mac_neg = 1'b0;
        mac_a = '0;
        mac_b = '0;
        if (state_reg == S_SQ)
        begin
            mac_clr = (step_reg == 5'd0);
            mac_a = (step_reg == 5'd0) ? rd_re_reg : rd_im_reg;
            mac_b = mac_a;
        end
        else if (!k[0])
        begin
            case (j)
                2'd0: begin mac_a = m_reg[{row, 2'd0}]; mac_b = ar_reg; end
                2'd1: begin mac_a = m_reg[{row, 2'd1}]; mac_b = ai_reg; mac_neg = 1'b1; end
                2'd2: begin mac_a = m_reg[{row, 2'd2}]; mac_b = br_reg; end
                default: begin mac_a = m_reg[{row, 2'd3}]; mac_b = bi_reg; mac_neg = 1'b1; end
            endcase
        end
        else
        begin
            case (j)
                2'd0: begin mac_a = m_reg[{row, 2'd0}]; mac_b = ai_reg; end
                2'd1: begin mac_a = m_reg[{row, 2'd1}]; mac_b = ar_reg; end
                2'd2: begin mac_a = m_reg[{row, 2'd2}]; mac_b = bi_reg; end
                default: begin mac_a = m_reg[{row, 2'd3}]; mac_b = br_reg; end
            endcase
        end
    end

    sqge_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mac_clr),
        .en    (mac_en),
        .neg   (mac_neg),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    assign we = (state_reg == S_CLEAR) || (state_reg == S_WRA) || (state_reg == S_WRB);
    assign wa = (state_reg == S_CLEAR) ? cnt_reg[ADDR_W-1:0] :
                (state_reg == S_WRB) ? (lo_addr | bit_mask) : lo_addr;
    assign wd_re = (state_reg == S_CLEAR) ? ((cnt_reg == '0) ? AMP_MAX : '0) :
                   (state_reg == S_WRB) ? nr_reg[2] : nr_reg[0];
    assign wd_im = (state_reg == S_CLEAR) ? '0 :
                   (state_reg == S_WRB) ? nr_reg[3] : nr_reg[1];
    assign ra = (state_reg == S_RDB) ? (lo_addr | bit_mask) : lo_addr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_re[wa] <= wd_re;
            mem_im[wa] <= wd_im;
        end
        rd_re_reg <= mem_re[ra];
        rd_im_reg <= mem_im[ra];
    end

    assign sq_round = mac_acc + (ACC_W'(1) << (FRAC_BITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            aq_reg    <= QCNT_W'(QUBITS);
            cnt_reg   <= '0;
            step_reg  <= '0;
            st_reg    <= 1'b0;
            ore_reg   <= '0;
            oim_reg   <= '0;
            prob_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                aq_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ore_reg  <= '0;
                        oim_reg  <= '0;
                        prob_reg <= '0;
                        st_reg   <= 1'b0;
                        cnt_reg  <= '0;
                        addr_reg <= idx;
                        t_reg    <= tq;
                        for (int i = 0; i < 8; i++)
                            m_reg[i] <= s_axis_tdata[16 + 16*i +: 16];
                        case (act)
                            ACT_INIT: state_reg <= S_CLEAR;
                            ACT_GATE:
                            begin
                                if (tq >= nq)
                                begin
                                    st_reg <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    addr_reg <= '0;
                                    state_reg <= S_RDA;
                                end
                            end
                            ACT_READ:
                            begin
                                if ((ADDR_W+1)'(idx) >= count)
                                begin
                                    st_reg <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_RDQ;
                            end
                            default:
                            begin
                                st_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (ADDR_W+1)'(DEPTH - 1))
                        state_reg <= S_OUT;
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB:
                begin
                    ar_reg <= rd_re_reg;
                    ai_reg <= rd_im_reg;
                    state_reg <= S_WAIT;
                    step_reg <= 5'd31;
                end
                S_WAIT:
                begin
                    if (step_reg == 5'd31)
                    begin
                        br_reg <= rd_re_reg;
                        bi_reg <= rd_im_reg;
                        step_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 5'd2)
                        begin
                            nr_reg[3] <= round_sat(mac_acc);
                            state_reg <= S_WRA;
                        end
                    end
                end
                S_MUL:
                begin
                    // The accumulator trails the issued step by the product and accumulator registers.
                    if (step_reg[1:0] == 2'd1 && step_reg[3:2] != 2'd0)
                        nr_reg[step_reg[3:2] - 2'd1] <= round_sat(mac_acc);
                    if (step_reg == 5'd15)
                    begin
                        step_reg <= '0;
                        state_reg <= S_WAIT;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_WRA: state_reg <= S_WRB;
                S_WRB:
                begin
                    if (((ADDR_W+1)'(lo_addr | bit_mask) + 1'b1) >= count)
                        state_reg <= S_OUT;
                    else
                    begin
                        addr_reg <= ((lo_addr | bit_mask) + 1'b1) & ~bit_mask;
                        state_reg <= S_RDA;
                    end
                end
                S_RDQ: state_reg <= S_RDQ2;
                S_RDQ2:
                begin
                    step_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    ore_reg <= rd_re_reg;
                    oim_reg <= rd_im_reg;
                    if (step_reg == 5'd1)
                    begin
                        step_reg <= '0;
                        state_reg <= S_SQW;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_SQW:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd1)
                    begin
                        if ((sq_round >> FRAC_BITS) > ACC_W'(1 << FRAC_BITS))
                            prob_reg <= 16'(1 << FRAC_BITS);
                        else
                            prob_reg <= sq_round[FRAC_BITS +: 16];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("ready while a result is pending");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && st_reg) |-> (ore_reg == '0 && prob_reg == '0))
        else $error("error result carries data");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped under stall");

endmodule

// File: bench/statevector_qubit_gate_engine_tb.sv
// ----------------------------------------------------------------------------
// Statevector gate engine testbench
// Drives init, gate and read requests across several qubit counts with random
// gaps on both streams, predicts every result with a fixed-point model of the
// state vector, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module statevector_qubit_gate_engine_tb
    import sqge_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [1:0]           action;
        logic [3:0]           target;
        logic [9:0]           index;
        logic signed [15:0]   m [8];
    } gate_req_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [15:0]        prob;
        logic               status;
    } amp_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [3:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;

    gate_req_t   pending_reqs [$];
    amp_result_t expected_amps [$];
    gate_req_t   offered_req;
    logic signed [15:0] sv_re [DEPTH];
    logic signed [15:0] sv_im [DEPTH];
    logic [3:0]  qubit_reg;
    logic        calm;
    int          errors;
    int          send_gap;
    int          recv_gap;
    int          results_seen;
    int          idle_cycles;

    statevector_qubit_gate_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_qubits();
        if (qubit_reg == 0)
            return 1;
        if (qubit_reg > QUBITS)
            return QUBITS;
        return qubit_reg;
    endfunction

    function automatic logic signed [15:0] q15_round(longint acc);
        longint r;
        r = (acc + 64'sd16384) >>> 15;
        if (r > 32767)
            return 16'sh7fff;
        if (r < -32768)
            return 16'sh8000;
        return r[15:0];
    endfunction

    function automatic amp_result_t apply_request(gate_req_t rq);
        amp_result_t res;
        int     nq;
        int     bitv;
        int     j;
        longint ar, ai, br, bi, sq;
        longint m [8];
        nq = eff_qubits();
        res = '{re: 0, im: 0, prob: 0, status: 1'b0};
        for (int k = 0; k < 8; k++)
            m[k] = rq.m[k];
        case (rq.action)
            ACT_INIT:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    sv_re[i] = 0;
                    sv_im[i] = 0;
                end
                sv_re[0] = AMP_MAX;
            end
            ACT_GATE:
            begin
                if (rq.target >= nq)
                    res.status = 1'b1;
                else
                begin
                    bitv = 1 << rq.target;
                    for (int i = 0; i < (1 << nq); i++)
                    begin
                        if ((i & bitv) == 0)
                        begin
                            j = i | bitv;
                            ar = sv_re[i];
                            ai = sv_im[i];
                            br = sv_re[j];
                            bi = sv_im[j];
                            sv_re[i] = q15_round(m[0]*ar - m[1]*ai + m[2]*br - m[3]*bi);
                            sv_im[i] = q15_round(m[0]*ai + m[1]*ar + m[2]*bi + m[3]*br);
                            sv_re[j] = q15_round(m[4]*ar - m[5]*ai + m[6]*br - m[7]*bi);
                            sv_im[j] = q15_round(m[4]*ai + m[5]*ar + m[6]*bi + m[7]*br);
                        end
                    end
                end
            end
            ACT_READ:
            begin
                if (rq.index >= (1 << nq))
                    res.status = 1'b1;
                else
                begin
                    ar = sv_re[rq.index];
                    ai = sv_im[rq.index];
                    sq = (ar*ar + ai*ai + 16384) >>> 15;
                    if (sq > 32768)
                        sq = 32768;
                    res.re = ar[15:0];
                    res.im = ai[15:0];
                    res.prob = sq[15:0];
                end
            end
            default:
                res.status = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic [143:0] pack_req(gate_req_t rq);
        logic [143:0] d;
        d = '0;
        d[1:0] = rq.action;
        d[5:2] = rq.target;
        d[15:6] = rq.index;
        for (int k = 0; k < 8; k++)
            d[16 + 16*k +: 16] = rq.m[k];
        return d;
    endfunction

    function automatic gate_req_t make_req(logic [1:0] act, int tgt, int idx,
                                           int m00r, int m00i, int m01r, int m01i,
                                           int m10r, int m10i, int m11r, int m11i);
        gate_req_t rq;
        rq.action = act;
        rq.target = tgt[3:0];
        rq.index = idx[9:0];
        rq.m[0] = m00r[15:0];
        rq.m[1] = m00i[15:0];
        rq.m[2] = m01r[15:0];
        rq.m[3] = m01i[15:0];
        rq.m[4] = m10r[15:0];
        rq.m[5] = m10i[15:0];
        rq.m[6] = m11r[15:0];
        rq.m[7] = m11i[15:0];
        return rq;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic gate_req_t random_req(int nq, ref int gates_left);
        gate_req_t rq;
        int r;
        r = $urandom_range(0, 99);
        rq = make_req(ACT_READ, $urandom_range(0, 15), $urandom_range(0, 1023),
                      0, 0, 0, 0, 0, 0, 0, 0);
        if (r >= 10 && r < 50 && gates_left == 0)
            r = 60;
        if (r < 8)
            rq.action = ACT_INIT;
        else if (r < 10)
            rq.action = 2'd3;
        else if (r < 50)
        begin
            gates_left--;
            rq.action = ACT_GATE;
            if ($urandom_range(0, 99) < 85)
                rq.target = $urandom_range(0, nq - 1);
            case ($urandom_range(0, 4))
                0: rq = make_req(ACT_GATE, rq.target, rq.index, 23170, 0, 23170, 0,
                                 23170, 0, -23170, 0);
                1: rq = make_req(ACT_GATE, rq.target, rq.index, 0, 0, 32767, 0,
                                 32767, 0, 0, 0);
                2: rq = make_req(ACT_GATE, rq.target, rq.index,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384,
                                 $urandom_range(0, 32767) - 16384);
                default:
                    for (int k = 0; k < 8; k++)
                        rq.m[k] = $urandom();
            endcase
        end
        else if ($urandom_range(0, 99) < 90)
            rq.index = $urandom_range(0, (1 << nq) - 1);
        return rq;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_amps.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_qubits(logic [3:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        qubit_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gate_req_t rq;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_amps.push_back(apply_request(offered_req));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    rq = pending_reqs.pop_front();
                    offered_req = rq;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pack_req(rq);
                    send_gap <= pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        amp_result_t want;
        amp_result_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.re = m_axis_tdata[15:0];
                got.im = m_axis_tdata[31:16];
                got.prob = m_axis_tdata[47:32];
                got.status = m_axis_tdata[48];
                results_seen <= results_seen + 1;
                if (expected_amps.size() == 0)
                begin
                    $error("unexpected result %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_amps.pop_front();
                    if (got.re !== want.re)
                    begin
                        $error("out_re: expected %0d, actual %0d", want.re, got.re);
                        errors++;
                    end
                    if (got.im !== want.im)
                    begin
                        $error("out_im: expected %0d, actual %0d", want.im, got.im);
                        errors++;
                    end
                    if (got.prob !== want.prob)
                    begin
                        $error("probability: expected %0d, actual %0d", want.prob, got.prob);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
            if (results_seen == 40 && m_axis_tvalid && m_axis_tready)
            begin
                recv_gap <= 400;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 30)
            begin
                recv_gap <= pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] settings [10];
        int gates_left;
        int nq;
        settings = '{4'd10, 4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd6, 4'd4, 4'd8, 4'd10};
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        qubit_reg = 4'd10;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 4'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        pending_reqs.push_back(make_req(ACT_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_GATE, 0, 0, 23170, 0, 23170, 0,
                                        23170, 0, -23170, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_GATE, 9, 0, 0, 0, 32767, 0, 32767, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 512, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_GATE, 10, 0, 1, 1, 1, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(ACT_GATE, 15, 1023, -1, -1, -1, -1,
                                        -1, -1, -1, -1));
        pending_reqs.push_back(make_req(2'd3, 15, 1023, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_reqs.push_back(make_req(ACT_GATE, 1, 0, 32767, 32767, 32767, 32767,
                                        32767, 32767, 32767, 32767));
        pending_reqs.push_back(make_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_GATE, 1, 0, -32768, -32768, -32768, -32768,
                                        -32768, -32768, -32768, -32768));
        pending_reqs.push_back(make_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        for (int p = 0; p < 10; p++)
        begin
            write_qubits(settings[p]);
            calm = (p % 3 == 2);
            nq = eff_qubits();
            gates_left = (nq >= 8) ? 3 : 1000;
            pending_reqs.push_back(make_req(ACT_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            for (int n = 0; n < 56; n++)
                pending_reqs.push_back(random_req(nq, gates_left));
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/sqge_pkg.sv
src/sqge_mac.sv
src/statevector_qubit_gate_engine.sv
bench/statevector_qubit_gate_engine_tb.sv
